// ----- hdl/md5_pkg.sv -----
// md5 core package: item types, round constants, padding constants and helpers
package md5_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef logic [31:0] word_t;

    typedef enum logic
    {
        OP_DATA   = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t        op;
        logic [7:0] data;
    } item_t;

    // back end sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PAD,
        ST_HASH,
        ST_EMIT
    } st_t;

    // padding phases
    typedef enum logic [1:0]
    {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN,
        PAD_END
    } pad_t;

    // round engine control and status
    typedef struct packed
    {
        logic start;
    } rnd_ctl_t;

    typedef struct packed
    {
        logic       busy;
        logic       done;
        logic [3:0] widx;
    } rnd_sts_t;

    localparam word_t INIT_A = 32'h67452301;
    localparam word_t INIT_B = 32'hefcdab89;
    localparam word_t INIT_C = 32'h98badcfe;
    localparam word_t INIT_D = 32'h10325476;

    localparam logic [7:0] MARK_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [5:0] LAST_ROUND  = 6'd63;

    localparam word_t K_ADD [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] K_ROT [0:15] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic word_t rotl(word_t x, logic [4:0] n);
        logic [4:0] m;
        m = 5'(6'd32 - {1'b0, n});
        return (x << n) | (x >> m);
    endfunction

endpackage

// ----- hdl/md5_message_digest_core.sv -----
// md5 message digest core top level
//
// md5 (rfc 1321) hash of a byte stream. each input word carries kind and
// data_byte: kind 0 appends data_byte to the message, kind 1 ends the message,
// pads it and returns the digest as four output words (word_index 0 to 3,
// last set on the fourth). each digest word is one whole chaining word, a in
// word 0 through d in word 3. after the digest the core is ready for a new
// message; an empty message is allowed. input words land in a small queue, so
// the input side keeps accepting while the hash engine or the output is busy,
// until the queue is full. the back end takes data bytes while idle; every
// 64th byte also starts a block compression by the single round unit that does
// one md5 round per cycle. a finish word writes 9 to 72 padding bytes at one
// byte per cycle outside the one or two compressions it runs, then emits four
// digest words, one per cycle when the output is not stalled.
module md5_message_digest_core
#(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    // digest words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last
);

    logic           q_valid;
    logic           q_pop;
    md5_pkg::item_t q_item;

    // front end: handshake and queue of classified words
    md5_front
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // back end: block buffer, padding, rounds and registered digest output
    md5_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last)
    );

endmodule

// ----- hdl/md5_front.sv -----
// md5 front end: input handshake, item classification and decoupling queue
module md5_front
#(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           kind,
    input  logic [7:0]     data_byte,
    output logic           q_valid,
    output md5_pkg::item_t q_item,
    input  logic           q_pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    md5_pkg::item_t slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push;
    logic           full;
    md5_pkg::item_t item_in;

    // classify the incoming word
    always_comb
    begin
        item_in.op   = kind ? md5_pkg::OP_FINISH : md5_pkg::OP_DATA;
        item_in.data = data_byte;
    end

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign in_stall = full;
    assign push     = in_valid && !full;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, q_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/md5_compress.sv -----
// md5 compression engine: one round per cycle over 64 rounds
module md5_compress
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  md5_pkg::rnd_ctl_t               ctl,
    output md5_pkg::rnd_sts_t               sts,
    input  logic [3:0][31:0]                chain,
    input  md5_pkg::word_t                  blk_word,
    output logic [3:0][31:0]                result
);

    logic [5:0]     rnd_reg;
    logic           busy_reg;
    logic           done_reg;
    md5_pkg::word_t a_reg, b_reg, c_reg, d_reg;
    md5_pkg::word_t f;
    md5_pkg::word_t sum;
    md5_pkg::word_t b_new;
    logic [1:0]     grp;
    logic [3:0]     r4;
    logic [3:0]     widx;

    assign grp = rnd_reg[5:4];
    assign r4  = rnd_reg[3:0];

    always_comb
    begin
        unique case (grp)
            2'd0:
            begin
                f    = (b_reg & c_reg) | (~b_reg & d_reg);
                widx = r4;
            end
            2'd1:
            begin
                f    = (b_reg & d_reg) | (c_reg & ~d_reg);
                widx = r4 * 4'd5 + 4'd1;
            end
            2'd2:
            begin
                f    = b_reg ^ c_reg ^ d_reg;
                widx = r4 * 4'd3 + 4'd5;
            end
            default:
            begin
                f    = c_reg ^ (b_reg | ~d_reg);
                widx = r4 * 4'd7;
            end
        endcase
    end

    assign sum   = a_reg + f + md5_pkg::K_ADD[rnd_reg] + blk_word;
    assign b_new = b_reg + md5_pkg::rotl(sum, md5_pkg::K_ROT[{grp, rnd_reg[1:0]}]);

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.widx = widx;
    assign result   = {d_reg, c_reg, b_reg, a_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg <= chain[0];
            b_reg <= chain[1];
            c_reg <= chain[2];
            d_reg <= chain[3];
        end
        else if (busy_reg)
        begin
            a_reg <= d_reg;
            b_reg <= b_new;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (rnd_reg == md5_pkg::LAST_ROUND);
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 1'b1;
                if (rnd_reg == md5_pkg::LAST_ROUND)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- hdl/md5_back.sv -----
// md5 back end: block buffer, padding sequencer, chaining words and digest output
module md5_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  md5_pkg::item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [31:0]    digest_word,
    output logic [1:0]     word_index,
    output logic           last
);

    md5_pkg::st_t      state_reg, state_next;
    md5_pkg::pad_t     phase_reg;
    logic              pad_active_reg;
    logic [2:0]        len_idx_reg;
    logic [63:0]       bits_reg;
    logic [63:0]       count_reg;
    logic [3:0][31:0]  chain_reg;
    md5_pkg::word_t    blk_reg [16];
    logic [1:0]        emit_idx_reg;
    logic              out_valid_reg;
    md5_pkg::word_t    out_word_reg;
    logic [1:0]        out_index_reg;
    logic              out_last_reg;

    logic [5:0]        pos;
    logic [5:0]        pos_inc;
    logic              out_free;
    logic              byte_we;
    logic [7:0]        byte_val;
    logic              fin_begin;
    logic              load_out;
    md5_pkg::rnd_ctl_t rnd_ctl;
    md5_pkg::rnd_sts_t rnd_sts;
    logic [3:0][31:0]  rnd_res;

    assign pos      = count_reg[5:0];
    assign pos_inc  = pos + 1'b1;
    assign out_free = !out_valid_reg || !out_stall;

    md5_compress u_compress
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rnd_ctl),
        .sts      (rnd_sts),
        .chain    (chain_reg),
        .blk_word (blk_reg[rnd_sts.widx]),
        .result   (rnd_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == md5_pkg::OP_FINISH)
                    begin
                        state_next = md5_pkg::ST_PAD;
                    end
                    else if (pos == md5_pkg::LAST_POS)
                    begin
                        state_next = md5_pkg::ST_HASH;
                    end
                end
            end
            md5_pkg::ST_PAD:
            begin
                if (pos == md5_pkg::LAST_POS)
                begin
                    state_next = md5_pkg::ST_HASH;
                end
            end
            md5_pkg::ST_HASH:
            begin
                if (rnd_sts.done)
                begin
                    if (!pad_active_reg)
                    begin
                        state_next = md5_pkg::ST_IDLE;
                    end
                    else if (phase_reg == md5_pkg::PAD_END)
                    begin
                        state_next = md5_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = md5_pkg::ST_PAD;
                    end
                end
            end
            md5_pkg::ST_EMIT:
            begin
                if (out_free && (emit_idx_reg == 2'd3))
                begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop         = 1'b0;
        byte_we       = 1'b0;
        byte_val      = q_item.data;
        fin_begin     = 1'b0;
        load_out      = 1'b0;
        rnd_ctl.start = 1'b0;
        unique case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                q_pop     = q_valid;
                byte_we   = q_valid && (q_item.op == md5_pkg::OP_DATA);
                fin_begin = q_valid && (q_item.op == md5_pkg::OP_FINISH);
                rnd_ctl.start = byte_we && (pos == md5_pkg::LAST_POS);
            end
            md5_pkg::ST_PAD:
            begin
                byte_we = 1'b1;
                case (phase_reg)
                    md5_pkg::PAD_MARK: byte_val = md5_pkg::MARK_BYTE;
                    md5_pkg::PAD_LEN:  byte_val = bits_reg[{len_idx_reg, 3'b000} +: 8];
                    default:           byte_val = 8'h00;
                endcase
                rnd_ctl.start = (pos == md5_pkg::LAST_POS);
            end
            md5_pkg::ST_EMIT:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    // block buffer, little-endian byte lanes
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            blk_reg[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= byte_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_begin)
        begin
            bits_reg <= {count_reg[60:0], 3'b000};
        end
        if (load_out)
        begin
            out_word_reg  <= chain_reg[emit_idx_reg];
            out_index_reg <= emit_idx_reg;
            out_last_reg  <= (emit_idx_reg == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= md5_pkg::ST_IDLE;
            phase_reg      <= md5_pkg::PAD_MARK;
            pad_active_reg <= 1'b0;
            len_idx_reg    <= '0;
            count_reg      <= '0;
            chain_reg      <= {md5_pkg::INIT_D, md5_pkg::INIT_C,
                               md5_pkg::INIT_B, md5_pkg::INIT_A};
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (byte_we)
            begin
                count_reg <= count_reg + 64'd1;
            end

            if (fin_begin)
            begin
                phase_reg      <= md5_pkg::PAD_MARK;
                pad_active_reg <= 1'b1;
                len_idx_reg    <= '0;
            end
            else if (state_reg == md5_pkg::ST_PAD)
            begin
                case (phase_reg) inside
                    md5_pkg::PAD_MARK, md5_pkg::PAD_ZERO:
                    begin
                        phase_reg <= (pos_inc == md5_pkg::LEN_POS) ? md5_pkg::PAD_LEN
                                                                   : md5_pkg::PAD_ZERO;
                    end
                    md5_pkg::PAD_LEN:
                    begin
                        len_idx_reg <= len_idx_reg + 1'b1;
                        if (len_idx_reg == 3'd7)
                        begin
                            phase_reg <= md5_pkg::PAD_END;
                        end
                    end
                    default:
                    begin
                        phase_reg <= phase_reg;
                    end
                endcase
            end

            if (rnd_sts.done)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + rnd_res[i];
                end
            end

            if (load_out)
            begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
                if (emit_idx_reg == 2'd3)
                begin
                    chain_reg      <= {md5_pkg::INIT_D, md5_pkg::INIT_C,
                                       md5_pkg::INIT_B, md5_pkg::INIT_A};
                    count_reg      <= '0;
                    pad_active_reg <= 1'b0;
                end
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_index  = out_index_reg;
    assign last        = out_last_reg;

    a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_sts.done |-> (state_reg == md5_pkg::ST_HASH))
        else $error("round engine finished outside hash state");

    a_start_idle_engine: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_ctl.start |-> !rnd_sts.busy)
        else $error("round engine restarted while busy");

    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == md5_pkg::ST_IDLE) && q_valid)
        else $error("queue popped outside idle or while empty");

    a_len_at_56: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_PAD && phase_reg == md5_pkg::PAD_LEN
         && len_idx_reg == 3'd0)
        |-> (pos == md5_pkg::LEN_POS))
        else $error("length field not placed at byte 56");

    a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && emit_idx_reg == 2'd3) |=> (count_reg == 64'd0) && !pad_active_reg)
        else $error("message state not cleared after last digest word");

endmodule
